[rtl/core/rkf_pkg.sv]
// Shared types, constants and register codes of the RGB 3x3 kernel filter.
`default_nettype none

package rkf_pkg;

    // default maximum image sizes; the width sets the line buffer depth
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // one packed RGB pixel, red in the top byte
    localparam int PIX_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // box blur: x / 9 == (x * 7282) >> 16 for every x below 32768
    localparam logic [12:0] BOX_RECIP = 13'd7282;
    localparam int          BOX_SHIFT = 16;

    // register reset values
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;
    localparam logic [10:0] RST_SEL_LEFT     = 11'd0;
    localparam logic [10:0] RST_SEL_TOP      = 11'd0;
    localparam logic [11:0] RST_SEL_RIGHT    = 12'd640;
    localparam logic [11:0] RST_SEL_BOTTOM   = 12'd480;

    typedef enum logic [1:0] {
        MODE_EDGE    = 2'd0,
        MODE_SHARPEN = 2'd1,
        MODE_BOX     = 2'd2,
        MODE_GAUSS   = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE  = 3'd0,
        REG_IMAGE_WIDTH  = 3'd1,
        REG_IMAGE_HEIGHT = 3'd2,
        REG_SEL_LEFT     = 3'd3,
        REG_SEL_TOP      = 3'd4,
        REG_SEL_RIGHT    = 3'd5,
        REG_SEL_BOTTOM   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       drain;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_end;
    } t_pix_out;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_req;

endpackage

`default_nettype wire

[rtl/core/rkf_stream_if.sv]
// Valid/ready channel carrying one request of a given payload type.
`default_nettype none

interface rkf_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/rkf_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module rkf_ram
    import rkf_pkg::*;
#(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = DEF_MAX_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/core/rgb_kernel_filter_3x3.sv]
// Top level of the streaming RGB 3x3 kernel filter.
`default_nettype none

// Streaming 3x3 convolution on 8-bit RGB pixels in raster order. The block takes one pixel
// request per cycle and returns one result per cycle once the pipeline is primed and the
// output is not stalled. Output lags the input stream by one row plus one pixel (W+1
// requests), so at the end of a frame the source sends W+1 drain requests to flush the
// tail; a drain with nothing pending yields no result. Each accepted request has its
// counters settled in the accept cycle, then reads both line buffers (one read port each,
// registered) and goes through the window and kernel logic into the output register in a
// single pass; that registered read of the line buffers sets the one-pixel-per-cycle rate.
// A result waiting in the output register holds an emitting request, and with it the pixel
// side. Border pixels, pixels outside the selection rectangle and drained pixels pass
// through unchanged. The line buffers are not cleared at reset: their contents are
// undefined until a full row has been written. Configuration is written through i_cfg
// (always ready) while the stream is idle; widths and heights beyond 1..MAX_WIDTH /
// 1..MAX_HEIGHT are clamped.
module rgb_kernel_filter_3x3
    import rkf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rkf_stream_if.sink   i_pix,
    rkf_stream_if.source o_res,
    rkf_stream_if.sink   i_cfg
);

    // column / row counters and sizes
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int XA = (WW > HW) ? WW : HW;
    localparam int XB = (XA > CFG_DATA_W) ? XA : CFG_DATA_W;
    localparam int XW = ((XB > PW) ? XB : PW) + 1;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    t_mode       r_filter_mode;
    logic [11:0] r_image_width;
    logic [11:0] r_image_height;
    logic [10:0] r_sel_left;
    logic [10:0] r_sel_top;
    logic [11:0] r_sel_right;
    logic [11:0] r_sel_bottom;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode  <= MODE_EDGE;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_image_height <= RST_IMAGE_HEIGHT;
            r_sel_left     <= RST_SEL_LEFT;
            r_sel_top      <= RST_SEL_TOP;
            r_sel_right    <= RST_SEL_RIGHT;
            r_sel_bottom   <= RST_SEL_BOTTOM;
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.index)
                REG_FILTER_MODE:  r_filter_mode  <= t_mode'(i_cfg.payload.data[1:0]);
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg.payload.data;
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg.payload.data;
                REG_SEL_LEFT:     r_sel_left     <= i_cfg.payload.data[10:0];
                REG_SEL_TOP:      r_sel_top      <= i_cfg.payload.data[10:0];
                REG_SEL_RIGHT:    r_sel_right    <= i_cfg.payload.data;
                REG_SEL_BOTTOM:   r_sel_bottom   <= i_cfg.payload.data;
                default: ;
            endcase
        end
    end

    // clamped image size
    logic [XW-1:0] eff_w;
    logic [XW-1:0] eff_h;

    always_comb begin
        if (r_image_width == '0) begin
            eff_w = XW'(1);
        end else if (XW'(r_image_width) > XW'(MAX_WIDTH)) begin
            eff_w = XW'(MAX_WIDTH);
        end else begin
            eff_w = XW'(r_image_width);
        end
        if (r_image_height == '0) begin
            eff_h = XW'(1);
        end else if (XW'(r_image_height) > XW'(MAX_HEIGHT)) begin
            eff_h = XW'(MAX_HEIGHT);
        end else begin
            eff_h = XW'(r_image_height);
        end
    end

    // ------------------------------------------------------------------
    // accept-side bookkeeping: positions and pending count
    // ------------------------------------------------------------------
    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_out_col;
    logic [RW-1:0] r_out_row;
    logic [PW-1:0] r_pend;

    logic [CW-1:0] n_in_col;
    logic [RW-1:0] n_in_row;
    logic [CW-1:0] n_out_col;
    logic [RW-1:0] n_out_row;
    logic [PW-1:0] n_pend;

    logic          pix_acc;
    logic          acc_drain;
    logic          acc_emit;
    logic          acc_two;
    logic          acc_load;
    logic          acc_fend;
    logic [CW-1:0] rd_addr;

    logic          s1_fire;
    logic          r_s1_valid;
    logic          r_s1_drain;
    logic          r_s1_emit;
    logic [CW-1:0] r_s1_addr;

    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign acc_drain   = i_pix.payload.drain;
    assign i_pix.ready = !r_s1_valid || s1_fire;

    // a pixel emits once more than W+1 are pending; a drain emits if any are
    always_comb begin
        if (acc_drain) begin
            acc_emit = (r_pend != '0);
            n_pend   = acc_emit ? r_pend - PW'(1) : r_pend;
        end else begin
            acc_emit = (XW'(r_pend) + XW'(1)) > (eff_w + XW'(1));
            n_pend   = acc_emit ? r_pend : r_pend + PW'(1);
        end
    end

    // drained pixel still sits in the older line when more than W remain
    assign acc_two  = (XW'(r_pend) - XW'(1)) >= eff_w;
    assign acc_load = pix_acc && (!acc_drain || acc_emit);
    assign acc_fend = (XW'(r_out_row) == eff_h - XW'(1)) &&
                      (XW'(r_out_col) == eff_w - XW'(1));
    assign rd_addr  = acc_drain ? r_out_col : r_in_col;

    // raster advance of the input position
    always_comb begin
        if (XW'(r_in_col) + XW'(1) >= eff_w) begin
            n_in_col = '0;
            n_in_row = (XW'(r_in_row) + XW'(1) >= eff_h) ? '0 : r_in_row + RW'(1);
        end else begin
            n_in_col = r_in_col + CW'(1);
            n_in_row = r_in_row;
        end
    end

    // raster advance of the output position
    always_comb begin
        if (XW'(r_out_col) + XW'(1) >= eff_w) begin
            n_out_col = '0;
            n_out_row = (XW'(r_out_row) + XW'(1) >= eff_h) ? '0 : r_out_row + RW'(1);
        end else begin
            n_out_col = r_out_col + CW'(1);
            n_out_row = r_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
        end else if (pix_acc) begin
            r_pend <= n_pend;
            if (!acc_drain) begin
                r_in_col <= n_in_col;
                r_in_row <= n_in_row;
            end
            if (acc_emit) begin
                r_out_col <= n_out_col;
                r_out_row <= n_out_row;
            end
        end
    end

    // ------------------------------------------------------------------
    // work stage: request register, line buffers, window, kernel
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_s1_px;
    logic [CW-1:0]    r_s1_col;
    logic [RW-1:0]    r_s1_row;
    logic             r_s1_fend;
    logic             r_s1_two;
    logic             r_fwd_hit;
    logic [PIX_W-1:0] r_fwd_above;
    logic [PIX_W-1:0] r_fwd_two;

    logic [PIX_W-1:0] above_q;
    logic [PIX_W-1:0] two_q;
    logic [PIX_W-1:0] above_eff;
    logic [PIX_W-1:0] two_eff;
    logic             s1_wr;

    logic             r_out_valid;
    t_pix_out         r_out;

    assign s1_fire = r_s1_valid && (!r_s1_emit || !r_out_valid || o_res.ready);
    assign s1_wr   = s1_fire && !r_s1_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // request payload; a line write landing in the read cycle is forwarded
    always_ff @(posedge i_clk) begin
        if (acc_load) begin
            r_s1_drain  <= acc_drain;
            r_s1_emit   <= acc_emit;
            r_s1_px     <= {i_pix.payload.in_red, i_pix.payload.in_green,
                            i_pix.payload.in_blue};
            r_s1_addr   <= rd_addr;
            r_s1_col    <= r_out_col;
            r_s1_row    <= r_out_row;
            r_s1_fend   <= acc_fend;
            r_s1_two    <= acc_two;
            r_fwd_hit   <= s1_wr && (r_s1_addr == rd_addr);
            r_fwd_above <= r_s1_px;
            r_fwd_two   <= above_eff;
        end
    end

    assign above_eff = r_fwd_hit ? r_fwd_above : above_q;
    assign two_eff   = r_fwd_hit ? r_fwd_two   : two_q;

    // line one row up
    rkf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_above (
        .i_clk   (i_clk),
        .i_we    (s1_wr),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_px),
        .i_re    (pix_acc),
        .i_raddr (rd_addr),
        .o_rdata (above_q)
    );

    // line two rows up
    rkf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (s1_wr),
        .i_waddr (r_s1_addr),
        .i_wdata (above_eff),
        .i_re    (pix_acc),
        .i_raddr (rd_addr),
        .o_rdata (two_q)
    );

    // window: middle and right columns kept, index 0 top .. 2 bottom
    logic [PIX_W-1:0] r_win_mid   [3];
    logic [PIX_W-1:0] r_win_right [3];
    logic [PIX_W-1:0] new_col     [3];

    assign new_col[0] = two_eff;
    assign new_col[1] = above_eff;
    assign new_col[2] = r_s1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win_mid[r]   <= '0;
                r_win_right[r] <= '0;
            end
        end else if (s1_wr) begin
            for (int r = 0; r < 3; r++) begin
                r_win_mid[r]   <= r_win_right[r];
                r_win_right[r] <= new_col[r];
            end
        end
    end

    // one channel of the kernel, truncated toward zero and clamped to 0..255
    function automatic logic [7:0] conv_chan(
        input t_mode      mode,
        input logic [7:0] tl, input logic [7:0] tm, input logic [7:0] tr,
        input logic [7:0] ml, input logic [7:0] mm, input logic [7:0] mr,
        input logic [7:0] bl, input logic [7:0] bm, input logic [7:0] br
    );
        logic [11:0]        all_sum;
        logic [11:0]        cross_sum;
        logic [11:0]        corner_sum;
        logic [11:0]        gauss_sum;
        logic [11:0]        nine_mm;
        logic [11:0]        five_mm;
        logic [24:0]        prod;
        logic signed [13:0] v;
        logic [7:0]         res;
        corner_sum = 12'(tl) + 12'(tr) + 12'(bl) + 12'(br);
        cross_sum  = 12'(tm) + 12'(ml) + 12'(mr) + 12'(bm);
        all_sum    = corner_sum + cross_sum + 12'(mm);
        gauss_sum  = corner_sum + (cross_sum << 1) + (12'(mm) << 2);
        nine_mm    = (12'(mm) << 3) + 12'(mm);
        five_mm    = (12'(mm) << 2) + 12'(mm);
        prod       = 25'(all_sum) * 25'(BOX_RECIP);
        case (mode)
            MODE_EDGE:    v = $signed({2'b00, nine_mm}) - $signed({2'b00, all_sum});
            MODE_SHARPEN: v = $signed({2'b00, five_mm}) - $signed({2'b00, cross_sum});
            MODE_BOX:     v = $signed({5'b0, prod[BOX_SHIFT+8:BOX_SHIFT]});
            MODE_GAUSS:   v = $signed({6'b0, gauss_sum[11:4]});
            default:      v = '0;
        endcase
        if (v < 0) begin
            res = 8'd0;
        end else if (v > 14'sd255) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    logic [PIX_W-1:0] conv_px;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            conv_px[c*8 +: 8] = conv_chan(r_filter_mode,
                r_win_mid[0][c*8 +: 8], r_win_right[0][c*8 +: 8], new_col[0][c*8 +: 8],
                r_win_mid[1][c*8 +: 8], r_win_right[1][c*8 +: 8], new_col[1][c*8 +: 8],
                r_win_mid[2][c*8 +: 8], r_win_right[2][c*8 +: 8], new_col[2][c*8 +: 8]);
        end
    end

    // interior pixel inside the selection rectangle
    logic             in_sel;
    logic [PIX_W-1:0] res_px;

    assign in_sel = !r_s1_drain &&
                    (r_s1_row != '0) && (XW'(r_s1_row) + XW'(1) < eff_h) &&
                    (r_s1_col != '0) && (XW'(r_s1_col) + XW'(1) < eff_w) &&
                    (XW'(r_s1_col) >= XW'(r_sel_left)) && (XW'(r_s1_col) < XW'(r_sel_right)) &&
                    (XW'(r_s1_row) >= XW'(r_sel_top))  && (XW'(r_s1_row) < XW'(r_sel_bottom));

    always_comb begin
        if (r_s1_drain) begin
            res_px = r_s1_two ? two_eff : above_eff;
        end else if (in_sel) begin
            res_px = conv_px;
        end else begin
            res_px = r_win_right[1];
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_emit) begin
            r_out.out_red   <= res_px[23:16];
            r_out.out_green <= res_px[15:8];
            r_out.out_blue  <= res_px[7:0];
            r_out.frame_end <= r_s1_fend;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

`default_nettype wire

[rtl/core/rkf_checker.sv]
// Port-level assertions for the RGB 3x3 kernel filter, bound to its top level.
`default_nettype none

module rkf_checker
    import rkf_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_pix_valid,
    input logic     i_pix_ready,
    input logic     i_res_valid,
    input logic     i_res_ready,
    input t_pix_out i_res_payload
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result request dropped while stalled");

    // a stalled result keeps its payload
    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_res_payload))
        else $error("result payload changed while stalled");

    // a fresh result follows an accepted pixel request
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(i_pix_valid && i_pix_ready, 2))
        else $error("result appeared without a preceding pixel request");

    // with room at the output the pixel side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_res_valid || i_res_ready) |-> i_pix_ready)
        else $error("pixel side stalled with a free output register");

endmodule

bind rgb_kernel_filter_3x3 rkf_checker u_rkf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_pix_valid   (i_pix.valid),
    .i_pix_ready   (i_pix.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_res_payload (o_res.payload)
);

`default_nettype wire

[test/tb_rgb_kernel_filter_3x3.sv]
// Self-checking testbench of the RGB 3x3 kernel filter: random frames against a pixel predictor.
`timescale 1ns / 1ps

module tb_rgb_kernel_filter_3x3;
    import rkf_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_W = DEF_MAX_WIDTH;
    localparam int MAX_H = DEF_MAX_HEIGHT;
    localparam int RAND_ITEMS = 1600;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_PRINTS = 30;

    // Predicts the filtered pixel stream and checks the results against it
    class rkf_scoreboard;
        t_mode       mode;
        logic [11:0] width_reg, height_reg, right_reg, bottom_reg;
        logic [10:0] left_reg, top_reg;
        logic [23:0] row_above[MAX_W];
        logic [23:0] row_two_above[MAX_W];
        logic [23:0] win[3][3];
        int          in_col, in_row, out_col, out_row, pending;
        t_pix_out    filtered_q[$];
        int          n_err, n_results, n_pixels, n_drains;

        function new();
            mode       = MODE_EDGE;
            width_reg  = RST_IMAGE_WIDTH;
            height_reg = RST_IMAGE_HEIGHT;
            left_reg   = RST_SEL_LEFT;
            top_reg    = RST_SEL_TOP;
            right_reg  = RST_SEL_RIGHT;
            bottom_reg = RST_SEL_BOTTOM;
            for (int i = 0; i < MAX_W; i++) begin
                row_above[i]     = '0;
                row_two_above[i] = '0;
            end
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) win[r][c] = '0;
            end
            in_col = 0; in_row = 0; out_col = 0; out_row = 0; pending = 0;
            n_err = 0; n_results = 0; n_pixels = 0; n_drains = 0;
        endfunction

        function int eff_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int eff_h();
            if (height_reg == 0) return 1;
            if (height_reg > MAX_H) return MAX_H;
            return height_reg;
        endfunction

        function void write_cfg(t_reg_idx idx, logic [11:0] d);
            case (idx)
                REG_FILTER_MODE:  mode       = t_mode'(d[1:0]);
                REG_IMAGE_WIDTH:  width_reg  = d;
                REG_IMAGE_HEIGHT: height_reg = d;
                REG_SEL_LEFT:     left_reg   = d[10:0];
                REG_SEL_TOP:      top_reg    = d[10:0];
                REG_SEL_RIGHT:    right_reg  = d;
                REG_SEL_BOTTOM:   bottom_reg = d;
                default: ;
            endcase
        endfunction

        // kernel sum of one color channel of the window, clamped to a byte
        function logic [7:0] kernel_chan(int sh);
            int t[3][3];
            int all, v;
            all = 0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    t[r][c] = win[r][c][sh +: 8];
                    all += t[r][c];
                end
            end
            case (mode)
                MODE_EDGE:    v = 9 * t[1][1] - all;
                MODE_SHARPEN: v = 5 * t[1][1] - t[0][1] - t[1][0] - t[1][2] - t[2][1];
                MODE_BOX:     v = all / 9;
                default:      v = (t[0][0] + t[0][2] + t[2][0] + t[2][2]
                                   + 2 * (t[0][1] + t[1][0] + t[1][2] + t[2][1])
                                   + 4 * t[1][1]) / 16;
            endcase
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return v[7:0];
        endfunction

        // queue one output pixel and step the output raster position
        function void push_result(logic [23:0] px);
            t_pix_out o;
            int w, h;
            w = eff_w();
            h = eff_h();
            o.out_red   = px[23:16];
            o.out_green = px[15:8];
            o.out_blue  = px[7:0];
            o.frame_end = (out_row == h - 1 && out_col == w - 1);
            if (out_col + 1 >= w) begin
                out_col = 0;
                out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
            end else begin
                out_col++;
            end
            pending--;
            filtered_q.push_back(o);
        endfunction

        // accepted pixel or drain request; returns 0 when the request had no effect
        function bit note_pixel(t_pix_in p);
            int w, h, idx;
            logic [23:0] px, res;
            w = eff_w();
            h = eff_h();
            if (p.drain) begin
                if (pending == 0) return 0;
                n_drains++;
                idx = out_col % MAX_W;
                px = (pending - 1 >= w) ? row_two_above[idx] : row_above[idx];
                push_result(px);
                return 1;
            end
            n_pixels++;
            px = {p.in_red, p.in_green, p.in_blue};
            idx = in_col % MAX_W;
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = row_two_above[idx];
            win[1][2] = row_above[idx];
            win[2][2] = px;
            row_two_above[idx] = row_above[idx];
            row_above[idx] = px;
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            pending++;
            if (pending > w + 1) begin
                res = win[1][1];
                // interior pixel inside the selection gets the kernel
                if (out_row > 0 && out_row + 1 < h && out_col > 0 && out_col + 1 < w &&
                    out_col >= left_reg && out_col < right_reg &&
                    out_row >= top_reg && out_row < bottom_reg) begin
                    res = {kernel_chan(16), kernel_chan(8), kernel_chan(0)};
                end
                push_result(res);
            end
            return 1;
        endfunction

        task report_mismatch(string msg);
            n_err++;
            if (n_err <= MAX_PRINTS) $display("result %0d: %s", n_results, msg);
        endtask

        task check(t_pix_out got);
            t_pix_out want;
            n_results++;
            if (filtered_q.size() == 0) begin
                report_mismatch("arrived with nothing predicted");
                return;
            end
            want = filtered_q.pop_front();
            if (got.out_red !== want.out_red)
                report_mismatch($sformatf("red %0d, predicted %0d", got.out_red, want.out_red));
            if (got.out_green !== want.out_green)
                report_mismatch($sformatf("green %0d, predicted %0d",
                                          got.out_green, want.out_green));
            if (got.out_blue !== want.out_blue)
                report_mismatch($sformatf("blue %0d, predicted %0d", got.out_blue, want.out_blue));
            if (got.frame_end !== want.frame_end)
                report_mismatch($sformatf("frame_end %0b, predicted %0b",
                                          got.frame_end, want.frame_end));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    rkf_stream_if #(.T(t_pix_in))  pix_if ();
    rkf_stream_if #(.T(t_pix_out)) res_if ();
    rkf_stream_if #(.T(t_cfg_req)) cfg_if ();

    rgb_kernel_filter_3x3 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    rkf_scoreboard sb;
    t_pix_in       drain_req;
    int            n_items;
    int            n_settings;
    int            n_holds;
    int            cycles;
    bit            no_gaps;
    bit            hold_sink;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // random pixel, biased toward the channel extremes
    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        logic [7:0] ch[3];
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 7))
                0: ch[i] = 8'd0;
                1: ch[i] = 8'd255;
                default: ch[i] = 8'($urandom_range(0, 255));
            endcase
        end
        p.in_red   = ch[0];
        p.in_green = ch[1];
        p.in_blue  = ch[2];
        p.drain    = 1'b0;
        return p;
    endfunction

    function automatic void pick_span(int n, output int lo, output int hi);
        case ($urandom_range(0, 3))
            0: begin lo = 0; hi = 2048; end
            1: begin lo = $urandom_range(1, n + 1); hi = $urandom_range(0, lo); end
            default: begin lo = $urandom_range(0, n); hi = $urandom_range(lo, n + 1); end
        endcase
    endfunction

    // send one pixel request after a random gap, note it once accepted
    task automatic send_item(t_pix_in p);
        int gap, r;
        gap = 0;
        if (!no_gaps) begin
            r = $urandom_range(0, 99);
            if (r >= 95) gap = $urandom_range(8, 40);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.payload <= p;
        do @(posedge i_clk); while (!pix_if.ready);
        if (sb.note_pixel(p)) n_items++;
    endtask

    task automatic send_pixels(int n, bit noisy);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 7) == 0) send_item(drain_req);
            send_item(rand_pixel());
        end
    endtask

    // drain until nothing is pending
    task automatic flush();
        while (sb.pending != 0) send_item(drain_req);
    endtask

    // bring input and output positions back to the start of a frame
    task automatic realign();
        while (sb.in_col != 0 || sb.in_row != 0) send_item(rand_pixel());
        flush();
    endtask

    // stream idle: every result in, then a settling wait for a drain that emitted nothing
    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (sb.filtered_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int v);
        t_cfg_req req;
        req.index = idx;
        req.data  = v[11:0];
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= req;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_cfg(idx, v[11:0]);
    endtask

    task automatic set_regs(t_mode m, int w, int h, int l, int t, int r, int b);
        wait_idle();
        write_reg(REG_FILTER_MODE, m);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_SEL_LEFT, l);
        write_reg(REG_SEL_TOP, t);
        write_reg(REG_SEL_RIGHT, r);
        write_reg(REG_SEL_BOTTOM, b);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    // result side: random ready stretches, one long hold when asked
    initial begin
        int r, len;
        bit level;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_sink) begin
                hold_sink = 1'b0;
                n_holds++;
                level = 1'b0;
                len = HOLD_CYCLES;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin level = 1'b1; len = $urandom_range(1, 16); end
                else if (r < 95) begin level = 1'b0; len = $urandom_range(1, 3); end
                else if (r < 98) begin level = 1'b0; len = $urandom_range(20, 60); end
                else begin level = 1'b1; len = $urandom_range(100, 300); end
            end
            res_if.ready <= level;
            repeat (len) begin
                @(posedge i_clk);
                if (res_if.valid && res_if.ready) sb.check(res_if.payload);
                // start a requested hold right away, while the sender is still busy
                if (hold_sink) break;
            end
        end
    end

    // watchdog
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("rgb_kernel_filter_3x3: mismatch");
        $finish;
    end

    // stimulus
    initial begin
        t_pix_in center, ring;
        int w, h, l, t, r, b, frames, frame_len, rand_start, phase;
        bit noisy, pressure;

        sb = new();
        n_items = 0; n_settings = 0; n_holds = 0;
        no_gaps = 1'b0;
        hold_sink = 1'b0;
        drain_req = '0;
        drain_req.drain = 1'b1;
        i_rst_n        <= 1'b0;
        pix_if.valid   <= 1'b0;
        pix_if.payload <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.payload <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // edge kernel on one 3x3 frame: bright center clamps high, dark center clamps low
        set_regs(MODE_EDGE, 3, 3, 0, 0, 2048, 2048);
        center = '{in_red: 8'd255, in_green: 8'd0, in_blue: 8'd255, drain: 1'b0};
        ring   = '{in_red: 8'd0, in_green: 8'd255, in_blue: 8'd0, drain: 1'b0};
        for (int i = 0; i < 9; i++) send_item((i == 4) ? center : ring);
        repeat (4) send_item(drain_req);
        send_item(drain_req);

        // premature drain in the middle of a frame
        set_regs(MODE_SHARPEN, 3, 3, 0, 0, 2048, 2048);
        for (int i = 0; i < 5; i++) send_item((i % 2 == 0) ? center : ring);
        send_item(drain_req);
        flush();

        // width shrinks while the positions stand beyond it
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_FILTER_MODE, MODE_BOX);
        cfg_if.valid <= 1'b0;
        n_settings++;
        send_pixels(3, 1'b0);
        flush();
        realign();

        // clamped and extreme sizes, partial frames to keep the run short
        no_gaps = 1'b1;
        set_regs(MODE_GAUSS, 4095, 3, 0, 0, 4095, 4095);
        send_pixels(20, 1'b0);
        flush();
        set_regs(MODE_EDGE, 1, 4095, 2047, 2047, 2048, 2048);
        send_pixels(40, 1'b0);
        flush();
        no_gaps = 1'b0;
        set_regs(MODE_SHARPEN, 0, 0, 0, 0, 0, 0);
        send_pixels(sb.eff_w() * sb.eff_h(), 1'b0);
        flush();
        send_item(drain_req);
        set_regs(MODE_BOX, 5, 4, 1, 1, 4, 3);
        send_pixels(sb.eff_w() * sb.eff_h(), 1'b0);
        flush();

        // random settings and frames, some with stray and early drains
        rand_start = n_items;
        phase = 0;
        while (n_items < rand_start + RAND_ITEMS) begin
            pressure = (phase == 2);
            if (pressure) begin
                w = 10;
                h = 20;
            end else begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
            pick_span(w, l, r);
            pick_span(h, t, b);
            set_regs(t_mode'($urandom_range(0, 3)), w, h, l, t, r, b);
            no_gaps = pressure || ($urandom_range(0, 3) == 0);
            noisy = !pressure && ($urandom_range(0, 3) == 0);
            if (pressure) hold_sink = 1'b1;
            frames = $urandom_range(1, 3);
            frame_len = sb.eff_w() * sb.eff_h();
            for (int f = 0; f < frames; f++) begin
                send_pixels(frame_len, noisy);
                if (f == frames - 1 || $urandom_range(0, 1) == 1) flush();
            end
            if (noisy) begin
                send_pixels($urandom_range(1, frame_len), 1'b1);
                realign();
            end
            if ($urandom_range(0, 1) == 1) send_item(drain_req);
            phase++;
        end
        no_gaps = 1'b0;
        wait_idle();

        $display("covered %0d pixels, %0d drains and %0d results over %0d register settings",
                 sb.n_pixels, sb.n_drains, sb.n_results, n_settings);
        $display("all four kernels, clamped sizes, empty selections, early drains, %0d output hold",
                 n_holds);
        if (sb.n_err == 0 && sb.filtered_q.size() == 0) begin
            $display("rgb_kernel_filter_3x3: match");
        end else begin
            $display("rgb_kernel_filter_3x3: mismatch");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rkf_pkg.sv
rtl/core/rkf_stream_if.sv
rtl/core/rkf_ram.sv
rtl/core/rgb_kernel_filter_3x3.sv
rtl/core/rkf_checker.sv
test/tb_rgb_kernel_filter_3x3.sv
